FILE: src/ddo_pkg.sv
// shared types, constants and tables of the differential-drive odometry block
// no dependencies
package ddo_pkg;

  localparam int NUM_WHEELS   = 4;
  localparam int WHEEL_W      = $clog2(NUM_WHEELS);
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_DEPTH   = 24;
  localparam int ATAN_IW      = $clog2(ATAN_DEPTH);
  localparam int CW           = 38;
  localparam int ZW           = 34;
  localparam int MW           = 34;
  localparam int PW           = 2 * MW;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W    = 104;
  localparam int OUT_DATA_W   = 176;

  localparam logic [31:0] RPM_SCALE_RST = 32'd34182364;
  localparam logic [23:0] INV_TRACK_RST = 24'd218453;
  localparam logic signed [CW-1:0] CORDIC_K = 38'sd652032874;
  localparam logic [32:0] YAW_RND = 33'd1 << (31 - ANGLE_BITS);

  localparam logic REG_RPM_SCALE = 1'b0;
  localparam logic REG_INV_TRACK = 1'b1;

  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [1:0] {
    KIND_ENC  = 2'd0,
    KIND_RPM  = 2'd1,
    KIND_IMU  = 2'd2,
    KIND_TICK = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QMUL, ST_QPRE, ST_QCOR, ST_ENC, ST_ECOR, ST_PX, ST_AX, ST_AY,
    ST_RPM, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_HCOR
  } st_e;

  typedef struct packed {
    kind_e                kind;
    logic [WHEEL_W-1:0]   wheel;
    logic signed [31:0]   sample;
    logic signed [15:0]   qw;
    logic signed [15:0]   qx;
    logic signed [15:0]   qy;
    logic signed [15:0]   qz;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

endpackage

FILE: src/ddo_front.sv
// input side: accepts stream transactions, classifies them and queues them
// depends on ddo_pkg
module ddo_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // wheel, sample, quat_w, quat_x, quat_y, quat_z, zero fill
  input  logic [ddo_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // action
  input  logic [1:0]                    s_axis_tuser,
  output logic                          item_valid_o,
  output ddo_pkg::item_t                item_o,
  input  logic                          item_ready_i
);
  import ddo_pkg::*;

  item_t               q_mem [QUEUE_DEPTH];
  item_t               in_item;
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                push, pop;

  always_comb begin
    in_item.kind   = kind_e'(s_axis_tuser);
    in_item.wheel  = s_axis_tdata[1:0];
    in_item.sample = s_axis_tdata[33:2];
    in_item.qw     = s_axis_tdata[49:34];
    in_item.qx     = s_axis_tdata[65:50];
    in_item.qy     = s_axis_tdata[81:66];
    in_item.qz     = s_axis_tdata[97:82];
  end

  assign s_axis_tready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != '0);
  assign pop           = item_valid_o && item_ready_i;
  assign item_o        = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= in_item;
  end

endmodule

FILE: src/ddo_cordic.sv
// shared iterative cordic, one micro-rotation per cycle, vectoring or rotating
// depends on ddo_pkg
module ddo_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ddo_pkg::cordic_req_t req_i,
  output ddo_pkg::cordic_rsp_t rsp_o
);
  import ddo_pkg::*;

  logic                 busy_q, done_q, vec_q, plus;
  logic [ATAN_IW-1:0]   it_q;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, at;

  always_comb begin
    xs   = x_q >>> it_q;
    ys   = y_q >>> it_q;
    at   = {{(ZW-32){1'b0}}, ATAN_TAB[it_q]};
    plus = vec_q ? (!y_q[CW-1] && (y_q != '0)) : z_q[ZW-1];
    if (plus) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == ATAN_IW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      z_q   <= req_i.z;
      vec_q <= req_i.vec;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.x    = x_q;
  assign rsp_o.y    = y_q;
  assign rsp_o.z    = z_q;

endmodule

FILE: src/ddo_back.sv
// execution side: wheel stores, yaw, pose integration, velocities, result register
// depends on ddo_pkg and a ddo_cordic instance beside it
module ddo_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           item_valid_i,
  input  ddo_pkg::item_t                 item_i,
  output logic                           item_ready_o,
  output ddo_pkg::cordic_req_t           cord_req_o,
  input  ddo_pkg::cordic_rsp_t           cord_rsp_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pos_x, pos_y, heading, orient_qz, orient_qw, vel_linear, vel_angular
  output logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ddo_pkg::*;

  function automatic logic [32:0] side_avg(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic va, input logic vb);
    logic signed [32:0] s;
    s = (33'(a) + 33'(b)) >>> 1;
    if (va && vb) return {1'b1, s[31:0]};
    else if (va) return {1'b1, a};
    else if (vb) return {1'b1, b};
    else return '0;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'h7FFFFFFF;
    else if (v < -48'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction

  function automatic logic [15:0] q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'h7FFF;
    else if (t < -34'sd32768) return 16'h8000;
    else return t[15:0];
  endfunction

  st_e                   state_q, state_d;
  logic signed [31:0]    enc_store_q [NUM_WHEELS], enc_store_d [NUM_WHEELS];
  logic signed [31:0]    rpm_store_q [NUM_WHEELS], rpm_store_d [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] enc_seen_q, enc_seen_d, rpm_seen_q, rpm_seen_d;
  logic                  imu_ready_q, imu_ready_d;
  logic [ANGLE_BITS-1:0] yaw_off_q, yaw_off_d, yaw_now_q, yaw_now_d, yaw_new;
  logic signed [31:0]    acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic signed [31:0]    last_l_q, last_l_d, last_r_q, last_r_d;
  logic [31:0]           rpm_scale_q;
  logic [23:0]           itw_q;
  logic signed [15:0]    qw_q, qw_d, qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic [2:0]            cnt_q, cnt_d;
  logic signed [32:0]    s_acc_q, s_acc_d, c_acc_q, c_acc_d;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_q, prod_d, t30;
  logic signed [31:0]    enc_l_q, enc_l_d, enc_r_q, enc_r_d, rpm_l_q, rpm_l_d, rpm_r_q, rpm_r_d;
  logic                  enc_ok_q, enc_ok_d, rpm_ok_q, rpm_ok_d;
  logic [32:0]           av_el, av_er, av_rl, av_rr;
  logic signed [32:0]    dist_q, dist_d;
  logic signed [33:0]    co_q, co_d, si_q, si_d, s_v, c_v;
  logic signed [40:0]    vl_q, vl_d, vr;
  logic signed [41:0]    dv;
  logic [41:0]           mag_q, mag_d;
  logic                  neg_q, neg_d, rot_neg_q, rot_neg_d, zneg;
  logic [50:0]           p1_q, p1_d, qsum;
  logic [31:0]           vx_q, vx_d, vz_q, vz_d;
  logic [15:0]           hz_q, hz_d, hw_q, hw_d;
  logic [31:0]           a32, ang;
  logic signed [31:0]    zsel;
  logic signed [ZW-1:0]  zx, zp;
  logic [32:0]           ang_r, hd;
  logic                  ov_q, ov_d;
  logic                  res_wait_q, res_wait_d;
  logic [OUT_DATA_W-1:0] od_q, od_d;

  assign a32   = {yaw_now_q, {(32-ANGLE_BITS){1'b0}}};
  assign hd    = {1'b0, a32} + 33'h8000;
  assign av_el = side_avg(enc_store_q[0], enc_store_q[2], enc_seen_q[0], enc_seen_q[2]);
  assign av_er = side_avg(enc_store_q[1], enc_store_q[3], enc_seen_q[1], enc_seen_q[3]);
  assign av_rl = side_avg(rpm_store_q[0], rpm_store_q[2], rpm_seen_q[0], rpm_seen_q[2]);
  assign av_rr = side_avg(rpm_store_q[1], rpm_store_q[3], rpm_seen_q[1], rpm_seen_q[3]);
  assign s_v   = {s_acc_q, 1'b0};
  assign c_v   = 34'sh40000000 - {c_acc_q, 1'b0};
  assign t30   = (prod_q + 68'sd536870912) >>> 30;
  assign vr    = prod_q[64:24];
  assign dv    = 42'(vr) - 42'(vl_q);
  assign qsum  = p1_q + 51'(prod_q[50:16]);
  assign ang   = (state_q == ST_QPRE) ? 32'd0 : cord_rsp_i.z[31:0];
  assign ang_r = {1'b0, ang} + YAW_RND;
  assign yaw_new = ang_r[31 -: ANGLE_BITS];

  // angle folding into the right half plane for the rotating cordic
  always_comb begin
    zsel = (state_q == ST_ENC) ? a32 : {a32[31], a32[31:1]};
    zx   = ZW'(zsel);
    zneg = 1'b1;
    if (zx > 34'sh40000000) zp = zx - 34'sh80000000;
    else if (zx < -34'sh40000000) zp = zx + 34'sh80000000;
    else begin
      zp   = zx;
      zneg = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    enc_store_d = enc_store_q;
    rpm_store_d = rpm_store_q;
    enc_seen_d  = enc_seen_q;
    rpm_seen_d  = rpm_seen_q;
    imu_ready_d = imu_ready_q;
    yaw_off_d   = yaw_off_q;
    yaw_now_d   = yaw_now_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    last_l_d    = last_l_q;
    last_r_d    = last_r_q;
    qw_d = qw_q; qx_d = qx_q; qy_d = qy_q; qz_d = qz_q;
    cnt_d   = cnt_q;
    s_acc_d = s_acc_q;
    c_acc_d = c_acc_q;
    enc_l_d = enc_l_q; enc_r_d = enc_r_q; enc_ok_d = enc_ok_q;
    rpm_l_d = rpm_l_q; rpm_r_d = rpm_r_q; rpm_ok_d = rpm_ok_q;
    dist_d = dist_q; co_d = co_q; si_d = si_q;
    vl_d = vl_q; mag_d = mag_q; neg_d = neg_q; p1_d = p1_q;
    vx_d = vx_q; vz_d = vz_q; hz_d = hz_q; hw_d = hw_q;
    rot_neg_d = rot_neg_q;
    mul_a = '0;
    mul_b = '0;
    cord_req_o = '0;
    item_ready_o = 1'b0;
    ov_d = ov_q;
    od_d = od_q;
    res_wait_d = res_wait_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          unique case (item_i.kind)
            KIND_ENC: begin
              enc_store_d[item_i.wheel] = item_i.sample;
              enc_seen_d[item_i.wheel]  = 1'b1;
            end
            KIND_RPM: begin
              rpm_store_d[item_i.wheel] = item_i.sample;
              rpm_seen_d[item_i.wheel]  = 1'b1;
            end
            KIND_IMU: begin
              qw_d = item_i.qw; qx_d = item_i.qx; qy_d = item_i.qy; qz_d = item_i.qz;
              cnt_d   = '0;
              s_acc_d = '0;
              c_acc_d = '0;
              state_d = ST_QMUL;
            end
            KIND_TICK: begin
              if (imu_ready_q) begin
                enc_ok_d = av_el[32] && av_er[32];
                enc_l_d  = av_el[31:0];
                enc_r_d  = av_er[31:0];
                rpm_ok_d = av_rl[32] && av_rr[32];
                rpm_l_d  = av_rl[31:0];
                rpm_r_d  = av_rr[31:0];
                state_d  = ST_ENC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_QMUL: begin
        unique case (cnt_q)
          3'd0: begin mul_a = MW'(qw_q); mul_b = MW'(qz_q); end
          3'd1: begin mul_a = MW'(qx_q); mul_b = MW'(qy_q); end
          3'd2: begin mul_a = MW'(qy_q); mul_b = MW'(qy_q); end
          3'd3: begin mul_a = MW'(qz_q); mul_b = MW'(qz_q); end
          default: ;
        endcase
        if (cnt_q == 3'd1 || cnt_q == 3'd2) s_acc_d = s_acc_q + $signed(prod_q[32:0]);
        if (cnt_q == 3'd3 || cnt_q == 3'd4) c_acc_d = c_acc_q + $signed(prod_q[32:0]);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd4) state_d = ST_QPRE;
      end
      ST_QPRE, ST_QCOR: begin
        if (state_q == ST_QPRE && (s_v != '0 || c_v != '0)) begin
          cord_req_o.start = 1'b1;
          cord_req_o.vec   = 1'b1;
          if (c_v[33]) begin
            cord_req_o.x = -CW'(c_v);
            cord_req_o.y = -CW'(s_v);
            cord_req_o.z = 34'sh80000000;
          end else begin
            cord_req_o.x = CW'(c_v);
            cord_req_o.y = CW'(s_v);
          end
          state_d = ST_QCOR;
        end else if (state_q == ST_QPRE || cord_rsp_i.done) begin
          if (!imu_ready_q) begin
            yaw_off_d   = yaw_new;
            imu_ready_d = 1'b1;
            yaw_now_d   = '0;
          end else begin
            yaw_now_d = yaw_new - yaw_off_q;
          end
          state_d = ST_IDLE;
        end
      end
      ST_ENC: begin
        if (enc_ok_q) begin
          dist_d   = 33'((34'(enc_l_q) - 34'(last_l_q) + 34'(enc_r_q) - 34'(last_r_q)) >>> 1);
          last_l_d = enc_l_q;
          last_r_d = enc_r_q;
          cord_req_o.start = 1'b1;
          cord_req_o.x     = CORDIC_K;
          cord_req_o.z     = zp;
          rot_neg_d        = zneg;
          state_d          = ST_ECOR;
        end else begin
          state_d = ST_RPM;
        end
      end
      ST_ECOR: begin
        if (cord_rsp_i.done) begin
          co_d    = 34'(rot_neg_q ? -cord_rsp_i.x : cord_rsp_i.x);
          si_d    = 34'(rot_neg_q ? -cord_rsp_i.y : cord_rsp_i.y);
          state_d = ST_PX;
        end
      end
      ST_PX: begin
        mul_a   = MW'(dist_q);
        mul_b   = co_q;
        state_d = ST_AX;
      end
      ST_AX: begin
        acc_x_d = sat32(48'(acc_x_q) + 48'(t30));
        mul_a   = MW'(dist_q);
        mul_b   = si_q;
        state_d = ST_AY;
      end
      ST_AY: begin
        acc_y_d = sat32(48'(acc_y_q) + 48'(t30));
        state_d = ST_RPM;
      end
      ST_RPM, ST_R5: begin
        if (state_q == ST_RPM && rpm_ok_q) begin
          mul_a   = MW'(rpm_l_q);
          mul_b   = MW'({1'b0, rpm_scale_q});
          state_d = ST_R1;
        end else begin
          if (state_q == ST_RPM) begin
            vx_d = '0;
            vz_d = '0;
          end else if (!neg_q) begin
            vz_d = (qsum > 51'h7FFFFFFF) ? 32'h7FFFFFFF : qsum[31:0];
          end else begin
            vz_d = (qsum > 51'h7FFFFFFF) ? 32'h80000000 : -qsum[31:0];
          end
          cord_req_o.start = 1'b1;
          cord_req_o.x     = CORDIC_K;
          cord_req_o.z     = zp;
          rot_neg_d        = zneg;
          state_d          = ST_HCOR;
        end
      end
      ST_R1: begin
        vl_d    = prod_q[64:24];
        mul_a   = MW'(rpm_r_q);
        mul_b   = MW'({1'b0, rpm_scale_q});
        state_d = ST_R2;
      end
      ST_R2: begin
        vx_d    = sat32((48'(vl_q) + 48'(vr)) >>> 1);
        neg_d   = dv[41];
        mag_d   = dv[41] ? -dv : dv;
        state_d = ST_R3;
      end
      ST_R3: begin
        mul_a   = MW'(mag_q[41:16]);
        mul_b   = MW'(itw_q);
        state_d = ST_R4;
      end
      ST_R4: begin
        p1_d    = prod_q[50:0];
        mul_a   = MW'(mag_q[15:0]);
        mul_b   = MW'(itw_q);
        state_d = ST_R5;
      end
      ST_HCOR: begin
        if (cord_rsp_i.done) begin
          hz_d = q15(34'(rot_neg_q ? -cord_rsp_i.y : cord_rsp_i.y));
          hw_d = q15(34'(rot_neg_q ? -cord_rsp_i.x : cord_rsp_i.x));
        end
        // result held here until the output register is free
        if (cord_rsp_i.done || res_wait_q) begin
          if (!ov_q || m_axis_tready) begin
            ov_d       = 1'b1;
            od_d       = {vz_q, vx_q, hw_d, hz_d, hd[31:16], acc_y_q, acc_x_q};
            res_wait_d = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            res_wait_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enc_seen_q  <= '0;
      rpm_seen_q  <= '0;
      imu_ready_q <= 1'b0;
      yaw_off_q   <= '0;
      yaw_now_q   <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      rpm_scale_q <= RPM_SCALE_RST;
      itw_q       <= INV_TRACK_RST;
      ov_q        <= 1'b0;
      res_wait_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      enc_seen_q  <= enc_seen_d;
      rpm_seen_q  <= rpm_seen_d;
      imu_ready_q <= imu_ready_d;
      yaw_off_q   <= yaw_off_d;
      yaw_now_q   <= yaw_now_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      ov_q        <= ov_d;
      res_wait_q  <= res_wait_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RPM_SCALE: rpm_scale_q <= cfg_data_i;
          REG_INV_TRACK: itw_q       <= cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    enc_store_q <= enc_store_d;
    rpm_store_q <= rpm_store_d;
    qw_q <= qw_d; qx_q <= qx_d; qy_q <= qy_d; qz_q <= qz_d;
    cnt_q   <= cnt_d;
    s_acc_q <= s_acc_d;
    c_acc_q <= c_acc_d;
    prod_q  <= prod_d;
    enc_l_q <= enc_l_d; enc_r_q <= enc_r_d; enc_ok_q <= enc_ok_d;
    rpm_l_q <= rpm_l_d; rpm_r_q <= rpm_r_d; rpm_ok_q <= rpm_ok_d;
    dist_q <= dist_d; co_q <= co_d; si_q <= si_d;
    vl_q <= vl_d; mag_q <= mag_d; neg_q <= neg_d; p1_q <= p1_d;
    vx_q <= vx_d; vz_q <= vz_d; hz_q <= hz_d; hw_q <= hw_d;
    rot_neg_q <= rot_neg_d;
    od_q <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

FILE: src/diff_drive_odometry_top.sv
// top level of the differential-drive odometry block
// depends on ddo_pkg, ddo_front, ddo_cordic and ddo_back
//
// Usage: sensor items enter on the s_axis channel, tuser carrying the item kind
// (encoder, rpm, imu quaternion, tick) and tdata the wheel, sample and quaternion.
// A two-entry queue in the front lets the sender keep going while the back works.
// Results leave on m_axis, one per tick once an imu item has been seen; other
// items only update state. Registers are written over the cfg channel, which is
// always ready; write them only while the block is idle.
// Encoder and rpm items are taken in the idle state of the back; imu and tick items
// wait mostly on the 16-step cordic, which is shared by the atan2 of the quaternion
// and the cos/sin of the pose and heading. Each item passes the input queue register
// before the back sees it. One item is worked on at a time.
// Reset clears position, yaw, seen flags and output valid and loads the register
// defaults. When the receiver stalls, the result stays in the output register and
// the back waits with the next result; the input queue then fills and tready falls.
module diff_drive_odometry_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // wheel, sample, quat_w, quat_x, quat_y, quat_z, zero fill
  input  logic [ddo_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // action
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, heading, orient_qz, orient_qw, vel_linear, vel_angular
  output logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import ddo_pkg::*;

  item_t       item;
  logic        item_valid, item_ready;
  cordic_req_t cord_req;
  cordic_rsp_t cord_rsp;

  assign cfg_ready_o = 1'b1;

  ddo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  ddo_cordic u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cord_req),
    .rsp_o (cord_rsp)
  );

  ddo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .cord_req_o   (cord_req),
    .cord_rsp_i   (cord_rsp),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
